>>> sv/fcte_pkg.sv
// fcte_pkg: shared types and constants for the chain table engine
// entry kinds, status codes, opcodes, datapath command and flag structs
// no dependencies
`timescale 1ns / 1ps

package fcte_pkg;

  // fixed field widths
  localparam int unsigned BLK_W   = 11;
  localparam int unsigned STEPS_W = 10;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_W   = 11;

  // default table depth and register reset
  localparam int unsigned ENTRIES_DEF = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // microprogram counter width
  localparam int unsigned UPC_W = 5;

  // opcodes
  localparam logic [OP_W-1:0] OP_NEW   = 3'd0;
  localparam logic [OP_W-1:0] OP_SEEK  = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINK = 2'd0,
    KIND_END  = 2'd1,
    KIND_FREE = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BROKEN = 2'd3
  } status_e;

  // table write selections
  typedef enum logic [2:0] {
    W_NONE      = 3'd0,
    W_CUR_LINK  = 3'd1,
    W_SCAN_END  = 3'd2,
    W_CUR_FREE  = 3'd3,
    W_CUR_INPUT = 3'd4
  } wsel_e;

  // count accumulator actions
  typedef enum logic [1:0] {
    A_NONE     = 2'd0,
    A_INC      = 2'd1,
    A_INC_FREE = 2'd2
  } acc_e;

  // result field updates
  typedef enum logic [1:0] {
    R_NONE  = 2'd0,
    R_ALLOC = 2'd1,
    R_READ  = 2'd2,
    R_WRITE = 2'd3
  } res_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_BLK_BAD     = 4'd2,
    C_WR_BAD      = 4'd3,
    C_SCAN_END    = 4'd4,
    C_RD_FREE     = 4'd5,
    C_RD_NOT_FREE = 4'd6,
    C_RD_NOT_END  = 4'd7,
    C_END_OR_STOP = 4'd8,
    C_I_FULL      = 4'd9,
    C_OP_EXT      = 4'd10
  } cond_e;

  // commands from sequencer to datapath
  typedef struct packed {
    logic    asel;      // read address: 0 cursor, 1 scan index
    wsel_e   wsel;
    logic    cur_link;  // cursor follows the link just read
    logic    scan_inc;
    logic    i_inc;
    acc_e    acc;
    res_e    res;
    logic    stat_we;
    status_e stat;
  } cmd_t;

  // status flags from datapath to sequencer
  typedef struct packed {
    logic blk_bad;
    logic wr_bad;
    logic scan_end;
    logic rd_free;
    logic rd_end;
    logic walk_stop;
    logic i_full;
    logic op_ext;
  } flags_t;

endpackage

>>> sv/fcte_seq.sv
// fcte_seq: microcoded sequencer for the chain table engine
// step counter, control store, jump conditions and request dispatch
// depends on fcte_pkg
`timescale 1ns / 1ps

module fcte_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fcte_pkg::OP_W-1:0] opcode_i,
  input  fcte_pkg::flags_t          flags_i,
  input  logic                      out_free_i,
  output fcte_pkg::cmd_t            cmd_o,
  output logic                      busy_o,
  output logic                      finish_o
);

  // step addresses
  localparam logic [fcte_pkg::UPC_W-1:0] S_FIN    = 5'd0;
  localparam logic [fcte_pkg::UPC_W-1:0] S_NOFREE = 5'd1;
  localparam logic [fcte_pkg::UPC_W-1:0] S_RANGE  = 5'd2;
  localparam logic [fcte_pkg::UPC_W-1:0] S_BROKEN = 5'd3;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FD0    = 5'd4;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FD1    = 5'd5;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FD2    = 5'd6;
  localparam logic [fcte_pkg::UPC_W-1:0] S_AL     = 5'd7;
  localparam logic [fcte_pkg::UPC_W-1:0] S_XL     = 5'd8;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WK0    = 5'd9;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WK1    = 5'd10;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WK2    = 5'd11;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WK3    = 5'd12;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WK4    = 5'd13;
  localparam logic [fcte_pkg::UPC_W-1:0] S_RD0    = 5'd14;
  localparam logic [fcte_pkg::UPC_W-1:0] S_RD1    = 5'd15;
  localparam logic [fcte_pkg::UPC_W-1:0] S_RD2    = 5'd16;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FR0    = 5'd17;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FR1    = 5'd18;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FR2    = 5'd19;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FR3    = 5'd20;
  localparam logic [fcte_pkg::UPC_W-1:0] S_FR4    = 5'd21;
  localparam logic [fcte_pkg::UPC_W-1:0] S_CT0    = 5'd22;
  localparam logic [fcte_pkg::UPC_W-1:0] S_CT1    = 5'd23;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WR0    = 5'd24;
  localparam logic [fcte_pkg::UPC_W-1:0] S_WR1    = 5'd25;

  typedef struct packed {
    fcte_pkg::cond_e              cond;
    logic [fcte_pkg::UPC_W-1:0]   target;
    logic                         scan_taken;  // bump scan index when jump taken
    fcte_pkg::cmd_t               cmd;
  } uword_t;

  logic [fcte_pkg::UPC_W-1:0] upc_q;
  logic                       busy_q;
  uword_t                     uw;
  logic                       taken;
  logic [fcte_pkg::UPC_W-1:0] entry;

  // first step of each opcode
  always_comb begin
    case (opcode_i)
      fcte_pkg::OP_NEW:   entry = S_FD0;
      fcte_pkg::OP_SEEK:  entry = S_WK0;
      fcte_pkg::OP_READ:  entry = S_RD0;
      fcte_pkg::OP_FREE:  entry = S_FR0;
      fcte_pkg::OP_COUNT: entry = S_CT0;
      fcte_pkg::OP_WRITE: entry = S_WR0;
      default:            entry = S_FIN;
    endcase
  end

  // control store
  always_comb begin
    uw        = '0;
    uw.cond   = fcte_pkg::C_ALWAYS;
    uw.target = S_FIN;
    case (upc_q)
      S_FIN: begin
      end
      S_NOFREE: begin
        uw.cmd.stat_we = 1'b1;
        uw.cmd.stat    = fcte_pkg::ST_NOFREE;
      end
      S_RANGE: begin
        uw.cmd.stat_we = 1'b1;
        uw.cmd.stat    = fcte_pkg::ST_RANGE;
      end
      S_BROKEN: begin
        uw.cmd.stat_we = 1'b1;
        uw.cmd.stat    = fcte_pkg::ST_BROKEN;
      end
      // lowest free entry search
      S_FD0: begin
        uw.cond     = fcte_pkg::C_SCAN_END;
        uw.target   = S_NOFREE;
        uw.cmd.asel = 1'b1;
      end
      S_FD1: begin
        uw.cond       = fcte_pkg::C_RD_NOT_FREE;
        uw.target     = S_FD0;
        uw.scan_taken = 1'b1;
      end
      S_FD2: begin
        uw.cond   = fcte_pkg::C_OP_EXT;
        uw.target = S_XL;
      end
      S_AL: begin
        uw.cmd.wsel = fcte_pkg::W_SCAN_END;
        uw.cmd.res  = fcte_pkg::R_ALLOC;
      end
      S_XL: begin
        uw.cmd.wsel = fcte_pkg::W_CUR_LINK;
        uw.target   = S_AL;
      end
      // chain walk before extending
      S_WK0: begin
        uw.cond   = fcte_pkg::C_BLK_BAD;
        uw.target = S_RANGE;
      end
      S_WK1: begin
        uw.cond = fcte_pkg::C_NEVER;
      end
      S_WK2: begin
        uw.cond   = fcte_pkg::C_RD_FREE;
        uw.target = S_BROKEN;
      end
      S_WK3: begin
        uw.cond   = fcte_pkg::C_END_OR_STOP;
        uw.target = S_FD0;
      end
      S_WK4: begin
        uw.cmd.cur_link = 1'b1;
        uw.cmd.i_inc    = 1'b1;
        uw.target       = S_WK1;
      end
      // single entry read
      S_RD0: begin
        uw.cond   = fcte_pkg::C_BLK_BAD;
        uw.target = S_RANGE;
      end
      S_RD1: begin
        uw.cond = fcte_pkg::C_NEVER;
      end
      S_RD2: begin
        uw.cmd.res = fcte_pkg::R_READ;
      end
      // chain release
      S_FR0: begin
        uw.cond   = fcte_pkg::C_BLK_BAD;
        uw.target = S_RANGE;
      end
      S_FR1: begin
        uw.cond = fcte_pkg::C_I_FULL;
      end
      S_FR2: begin
        uw.cond   = fcte_pkg::C_RD_FREE;
        uw.target = S_BROKEN;
      end
      S_FR3: begin
        uw.cond         = fcte_pkg::C_RD_NOT_END;
        uw.target       = S_FR1;
        uw.cmd.wsel     = fcte_pkg::W_CUR_FREE;
        uw.cmd.cur_link = 1'b1;
        uw.cmd.acc      = fcte_pkg::A_INC;
        uw.cmd.i_inc    = 1'b1;
      end
      S_FR4: begin
      end
      // free entry count
      S_CT0: begin
        uw.cond     = fcte_pkg::C_SCAN_END;
        uw.cmd.asel = 1'b1;
      end
      S_CT1: begin
        uw.cmd.acc      = fcte_pkg::A_INC_FREE;
        uw.cmd.scan_inc = 1'b1;
        uw.target       = S_CT0;
      end
      // raw entry write
      S_WR0: begin
        uw.cond   = fcte_pkg::C_WR_BAD;
        uw.target = S_RANGE;
      end
      S_WR1: begin
        uw.cmd.wsel = fcte_pkg::W_CUR_INPUT;
        uw.cmd.res  = fcte_pkg::R_WRITE;
      end
      default: begin
      end
    endcase
  end

  // jump condition select
  always_comb begin
    case (uw.cond)
      fcte_pkg::C_NEVER:       taken = 1'b0;
      fcte_pkg::C_ALWAYS:      taken = 1'b1;
      fcte_pkg::C_BLK_BAD:     taken = flags_i.blk_bad;
      fcte_pkg::C_WR_BAD:      taken = flags_i.wr_bad;
      fcte_pkg::C_SCAN_END:    taken = flags_i.scan_end;
      fcte_pkg::C_RD_FREE:     taken = flags_i.rd_free;
      fcte_pkg::C_RD_NOT_FREE: taken = !flags_i.rd_free;
      fcte_pkg::C_RD_NOT_END:  taken = !flags_i.rd_end;
      fcte_pkg::C_END_OR_STOP: taken = flags_i.rd_end || flags_i.walk_stop;
      fcte_pkg::C_I_FULL:      taken = flags_i.i_full;
      fcte_pkg::C_OP_EXT:      taken = flags_i.op_ext;
      default:                 taken = 1'b0;
    endcase
  end

  // resolved datapath command
  always_comb begin
    cmd_o          = uw.cmd;
    cmd_o.scan_inc = uw.cmd.scan_inc || (uw.scan_taken && taken);
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= S_FIN;
      busy_q <= 1'b0;
    end else if (start_i) begin
      upc_q  <= entry;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (upc_q == S_FIN) begin
        if (out_free_i) begin
          busy_q <= 1'b0;
        end
      end else begin
        upc_q <= taken ? uw.target : upc_q + 1'b1;
      end
    end
  end

  assign busy_o   = busy_q;
  assign finish_o = busy_q && (upc_q == S_FIN) && out_free_i;

  // idle sequencer parks on the final step
  a_idle_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> upc_q == S_FIN)
    else $error("sequencer idle away from final step");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("request taken without running the program");

  a_finish_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (upc_q == S_FIN) && out_free_i && !start_i |=> !busy_q)
    else $error("finished program still holds the sequencer");

endmodule

>>> sv/fcte_dpath.sv
// fcte_dpath: datapath of the chain table engine
// table memory with clearing pass, cursor, scan and walk counters, result fields
// depends on fcte_pkg
`timescale 1ns / 1ps

module fcte_dpath #(
  parameter int unsigned ENTRIES = fcte_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fcte_pkg::OP_W-1:0]     opcode_i,
  input  logic [fcte_pkg::BLK_W-1:0]    block_i,
  input  logic [fcte_pkg::STEPS_W-1:0]  steps_i,
  input  logic [fcte_pkg::KIND_W-1:0]   write_kind_i,
  input  logic [fcte_pkg::BLK_W-1:0]    write_link_i,
  input  logic [fcte_pkg::CFG_W-1:0]    cfg_entries_i,
  input  fcte_pkg::cmd_t                cmd_i,
  output fcte_pkg::flags_t              flags_o,
  output logic                          clearing_o,
  output logic [fcte_pkg::STAT_W-1:0]   status_o,
  output logic [fcte_pkg::BLK_W-1:0]    block_out_o,
  output logic [fcte_pkg::KIND_W-1:0]   kind_out_o,
  output logic [fcte_pkg::BLK_W-1:0]    count_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [fcte_pkg::KIND_W-1:0] kind;
    logic [IDX_W-1:0]            link;  // 0-based target
  } entry_t;

  // table storage
  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  // request fields
  logic [fcte_pkg::OP_W-1:0]    op_q;
  logic [fcte_pkg::BLK_W-1:0]   blk_q;
  logic [fcte_pkg::STEPS_W-1:0] steps_q;
  logic [fcte_pkg::KIND_W-1:0]  wkind_q;
  logic [fcte_pkg::BLK_W-1:0]   wlink_q;

  // working registers
  logic [IDX_W-1:0]            cur_q;
  logic [CNT_W-1:0]            scan_q;
  logic [CNT_W-1:0]            i_q;
  logic [fcte_pkg::BLK_W-1:0]  acc_q;
  logic [fcte_pkg::STAT_W-1:0] res_stat_q;
  logic [fcte_pkg::BLK_W-1:0]  res_bout_q;
  logic [fcte_pkg::KIND_W-1:0] res_kout_q;

  // clearing pass
  logic             clearing_q;
  logic [IDX_W-1:0] clr_idx_q;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  logic [fcte_pkg::KIND_W-1:0] in_kind;
  logic [IDX_W-1:0]            wlink_idx;
  logic [CNT_W-1:0]            rd_link_p1;
  logic                        acc_bump;
  logic                        wlink_bad;

  // write request decode, kind three stores free
  always_comb begin
    if (wkind_q == fcte_pkg::KIND_LINK) begin
      in_kind = fcte_pkg::KIND_LINK;
    end else if (wkind_q == fcte_pkg::KIND_END) begin
      in_kind = fcte_pkg::KIND_END;
    end else begin
      in_kind = fcte_pkg::KIND_FREE;
    end
  end

  assign wlink_idx  = IDX_W'(wlink_q - 1'b1);
  assign rd_link_p1 = CNT_W'(rdata_q.link) + 1'b1;

  // write port select
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = cur_q;
    mem_wdata.kind = fcte_pkg::KIND_FREE;
    mem_wdata.link = '0;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
    end else begin
      case (cmd_i.wsel)
        fcte_pkg::W_NONE: begin
        end
        fcte_pkg::W_CUR_LINK: begin
          mem_we         = 1'b1;
          mem_wdata.kind = fcte_pkg::KIND_LINK;
          mem_wdata.link = scan_q[IDX_W-1:0];
        end
        fcte_pkg::W_SCAN_END: begin
          mem_we         = 1'b1;
          mem_waddr      = scan_q[IDX_W-1:0];
          mem_wdata.kind = fcte_pkg::KIND_END;
        end
        fcte_pkg::W_CUR_FREE: begin
          mem_we = 1'b1;
        end
        fcte_pkg::W_CUR_INPUT: begin
          mem_we         = 1'b1;
          mem_wdata.kind = in_kind;
          mem_wdata.link = (in_kind == fcte_pkg::KIND_LINK) ? wlink_idx : '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_raddr = cmd_i.asel ? scan_q[IDX_W-1:0] : cur_q;

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_raddr];
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q    <= opcode_i;
      blk_q   <= block_i;
      steps_q <= steps_i;
      wkind_q <= write_kind_i;
      wlink_q <= write_link_i;
    end
  end

  assign acc_bump = (cmd_i.acc == fcte_pkg::A_INC) ||
                    ((cmd_i.acc == fcte_pkg::A_INC_FREE) &&
                     (rdata_q.kind == fcte_pkg::KIND_FREE));

  // cursor, counters and result fields
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cur_q      <= IDX_W'(block_i - 1'b1);
      scan_q     <= '0;
      i_q        <= '0;
      acc_q      <= '0;
      res_stat_q <= fcte_pkg::ST_OK;
      res_bout_q <= '0;
      res_kout_q <= '0;
    end else begin
      if (cmd_i.cur_link) begin
        cur_q <= rdata_q.link;
      end
      if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end
      // count saturates at all ones
      if (acc_bump && (acc_q != '1)) begin
        acc_q <= acc_q + 1'b1;
      end
      if (cmd_i.stat_we) begin
        res_stat_q <= cmd_i.stat;
      end
      case (cmd_i.res)
        fcte_pkg::R_NONE: begin
        end
        fcte_pkg::R_ALLOC: begin
          res_bout_q <= fcte_pkg::BLK_W'(scan_q + 1'b1);
          res_kout_q <= fcte_pkg::KIND_END;
        end
        fcte_pkg::R_READ: begin
          res_kout_q <= rdata_q.kind;
          res_bout_q <= (rdata_q.kind == fcte_pkg::KIND_LINK) ?
                        fcte_pkg::BLK_W'(rd_link_p1) : '0;
        end
        fcte_pkg::R_WRITE: begin
          res_kout_q <= in_kind;
          res_bout_q <= (in_kind == fcte_pkg::KIND_LINK) ? wlink_q : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // flags for the sequencer
  assign wlink_bad = (wlink_q == '0) || (32'(wlink_q) > ENTRIES);

  always_comb begin
    flags_o.blk_bad   = (blk_q == '0) || (32'(blk_q) > ENTRIES);
    flags_o.wr_bad    = flags_o.blk_bad ||
                        ((wkind_q == fcte_pkg::KIND_LINK) && wlink_bad);
    flags_o.scan_end  = (32'(scan_q) >= 32'(cfg_entries_i)) ||
                        (32'(scan_q) >= ENTRIES);
    flags_o.rd_free   = rdata_q.kind == fcte_pkg::KIND_FREE;
    flags_o.rd_end    = rdata_q.kind == fcte_pkg::KIND_END;
    flags_o.walk_stop = (32'(i_q) >= 32'(steps_q)) || (32'(i_q) >= ENTRIES);
    flags_o.i_full    = 32'(i_q) >= ENTRIES;
    flags_o.op_ext    = op_q == fcte_pkg::OP_SEEK;
  end

  assign clearing_o  = clearing_q;
  assign status_o    = res_stat_q;
  assign block_out_o = res_bout_q;
  assign kind_out_o  = res_kout_q;
  assign count_o     = acc_q;

  // program writes never collide with the clearing pass
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> cmd_i.wsel == fcte_pkg::W_NONE)
    else $error("table write during clearing pass");

  // allocation only targets an entry inside the usable range
  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wsel == fcte_pkg::W_SCAN_END |-> !flags_o.scan_end)
    else $error("allocation beyond usable entries");

endmodule

>>> sv/fat_chain_table_engine_unit.sv
// fat_chain_table_engine_unit: top level of the chain table engine
// request and result channels, table size register, result register
// depends on fcte_pkg, fcte_seq, fcte_dpath
`timescale 1ns / 1ps

// File allocation table engine over ENTRIES chain entries held in a memory with
// one read port, one write port and registered read. One request at a time; the
// result sits in an output register, so a new request can be taken while it
// waits. New chain scans the entries for the lowest free one; seek and extend
// follows links and then scans for the lowest free entry; free chain frees one
// entry per link followed; count free scans min(table_entries, ENTRIES) entries;
// an out of range block ends in a range status, and an unused opcode goes
// straight to the final step. While the previous result still waits in the
// output register the last step holds until it is taken. After reset the table
// is cleared one entry per cycle, and no request is taken during the clearing
// pass; the table size register is meant to be written
// only while no request is in flight.
module fat_chain_table_engine_unit #(
  parameter int unsigned ENTRIES = fcte_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // table size register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcte_pkg::CFG_W-1:0]    cfg_table_entries_i,
  // requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fcte_pkg::OP_W-1:0]     opcode_i,
  input  logic [fcte_pkg::BLK_W-1:0]    block_i,
  input  logic [fcte_pkg::STEPS_W-1:0]  steps_i,
  input  logic [fcte_pkg::KIND_W-1:0]   write_kind_i,
  input  logic [fcte_pkg::BLK_W-1:0]    write_link_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fcte_pkg::STAT_W-1:0]   status_o,
  output logic [fcte_pkg::BLK_W-1:0]    block_out_o,
  output logic [fcte_pkg::KIND_W-1:0]   kind_out_o,
  output logic [fcte_pkg::BLK_W-1:0]    count_o
);

  logic [fcte_pkg::CFG_W-1:0]  cfg_q;
  logic                        start;
  logic                        busy;
  logic                        finish;
  logic                        clearing;
  logic                        out_free;
  fcte_pkg::cmd_t              cmd;
  fcte_pkg::flags_t            flags;

  logic [fcte_pkg::STAT_W-1:0] res_stat;
  logic [fcte_pkg::BLK_W-1:0]  res_bout;
  logic [fcte_pkg::KIND_W-1:0] res_kout;
  logic [fcte_pkg::BLK_W-1:0]  res_count;

  logic                        out_valid_q;
  logic [fcte_pkg::STAT_W-1:0] out_stat_q;
  logic [fcte_pkg::BLK_W-1:0]  out_bout_q;
  logic [fcte_pkg::KIND_W-1:0] out_kout_q;
  logic [fcte_pkg::BLK_W-1:0]  out_count_q;

  // table size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fcte_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_table_entries_i;
    end
  end

  // request handshake
  assign in_ready_o = !busy && !clearing;
  assign start      = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  fcte_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .opcode_i   (opcode_i),
    .flags_i    (flags),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .finish_o   (finish)
  );

  fcte_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .opcode_i      (opcode_i),
    .block_i       (block_i),
    .steps_i       (steps_i),
    .write_kind_i  (write_kind_i),
    .write_link_i  (write_link_i),
    .cfg_entries_i (cfg_q),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .clearing_o    (clearing),
    .status_o      (res_stat),
    .block_out_o   (res_bout),
    .kind_out_o    (res_kout),
    .count_o       (res_count)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_stat_q  <= res_stat;
      out_bout_q  <= res_bout;
      out_kout_q  <= res_kout;
      out_count_q <= res_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign block_out_o = out_bout_q;
  assign kind_out_o  = out_kout_q;
  assign count_o     = out_count_q;

endmodule

>>> sim/fat_chain_table_checker.sv
// fat_chain_table_checker: watches the table size, request and result channels
// keeps its own copy of the chain table, predicts each result and compares
// depends on fcte_pkg
`timescale 1ns / 1ps

module fat_chain_table_checker
  import fcte_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CFG_W-1:0]   cfg_table_entries_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [BLK_W-1:0]   block_i,
  input  logic [STEPS_W-1:0] steps_i,
  input  logic [KIND_W-1:0]  write_kind_i,
  input  logic [BLK_W-1:0]   write_link_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [STAT_W-1:0]  status_i,
  input  logic [BLK_W-1:0]   block_out_i,
  input  logic [KIND_W-1:0]  kind_out_i,
  input  logic [BLK_W-1:0]   count_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] blk;
    kind_e            kind;
    logic [BLK_W-1:0] cnt;
  } table_result_t;

  // shadow chain table and table size register
  kind_e            tbl_kind [ENTRIES];
  logic [BLK_W-1:0] tbl_link [ENTRIES];
  logic [CFG_W-1:0] table_size;

  table_result_t pending_results [$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [BLK_W-1:0] got,
                                 input logic [BLK_W-1:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int entries_in_use();
    return (int'(table_size) > ENTRIES) ? ENTRIES : int'(table_size);
  endfunction

  function automatic bit block_ok(input logic [BLK_W-1:0] b);
    return (b >= 1) && (int'(b) <= ENTRIES);
  endfunction

  // lowest free entry among those in use, ENTRIES if there is none
  function automatic int lowest_free_entry();
    int idx;
    int found;
    found = ENTRIES;
    for (idx = entries_in_use() - 1; idx >= 0; idx--)
      if (tbl_kind[idx] == KIND_FREE) found = idx;
    return found;
  endfunction

  function automatic logic [BLK_W-1:0] clip_count(input int c);
    return (c > 2047) ? 11'h7ff : BLK_W'(c);
  endfunction

  // apply one request to the shadow table and return the result it gives
  function automatic table_result_t table_op_result(
    input logic [OP_W-1:0]    op,
    input logic [BLK_W-1:0]   blk,
    input logic [STEPS_W-1:0] steps,
    input logic [KIND_W-1:0]  wkind,
    input logic [BLK_W-1:0]   wlink
  );
    table_result_t    r;
    int               cur;
    int               f;
    int               i;
    int               tally;
    bit               broken;
    bit               walking;
    kind_e            k;
    logic [BLK_W-1:0] nxt;
    r.status = ST_OK;
    r.blk    = '0;
    r.kind   = KIND_LINK;
    r.cnt    = '0;
    case (op)
      OP_NEW: begin
        f = lowest_free_entry();
        if (f >= ENTRIES) begin
          r.status = ST_NOFREE;
        end else begin
          tbl_kind[f] = KIND_END;
          tbl_link[f] = '0;
          r.blk  = BLK_W'(f + 1);
          r.kind = KIND_END;
        end
      end
      OP_SEEK: begin
        if (!block_ok(blk)) begin
          r.status = ST_RANGE;
        end else begin
          // follow links until end of chain, a free entry, or the step budget runs out
          cur = int'(blk) - 1;
          i = 0;
          broken = 1'b0;
          walking = 1'b1;
          while (walking) begin
            if (tbl_kind[cur] == KIND_FREE) begin
              broken = 1'b1;
              walking = 1'b0;
            end else if (tbl_kind[cur] == KIND_END || i >= int'(steps) || i >= ENTRIES) begin
              walking = 1'b0;
            end else begin
              cur = int'(tbl_link[cur]) - 1;
              i++;
            end
          end
          if (broken) begin
            r.status = ST_BROKEN;
          end else begin
            f = lowest_free_entry();
            if (f >= ENTRIES) begin
              r.status = ST_NOFREE;
            end else begin
              tbl_kind[cur] = KIND_LINK;
              tbl_link[cur] = BLK_W'(f + 1);
              tbl_kind[f]   = KIND_END;
              tbl_link[f]   = '0;
              r.blk  = BLK_W'(f + 1);
              r.kind = KIND_END;
            end
          end
        end
      end
      OP_READ: begin
        if (!block_ok(blk)) begin
          r.status = ST_RANGE;
        end else begin
          cur = int'(blk) - 1;
          r.kind = tbl_kind[cur];
          r.blk  = (tbl_kind[cur] == KIND_LINK) ? tbl_link[cur] : '0;
        end
      end
      OP_FREE: begin
        if (!block_ok(blk)) begin
          r.status = ST_RANGE;
        end else begin
          // entries freed before a broken link stay freed
          cur = int'(blk) - 1;
          tally = 0;
          walking = 1'b1;
          for (i = 0; i < ENTRIES && walking; i++) begin
            k   = tbl_kind[cur];
            nxt = tbl_link[cur];
            if (k == KIND_FREE) begin
              r.status = ST_BROKEN;
              walking = 1'b0;
            end else begin
              tbl_kind[cur] = KIND_FREE;
              tbl_link[cur] = '0;
              tally++;
              if (k == KIND_END) walking = 1'b0;
              else cur = int'(nxt) - 1;
            end
          end
          r.cnt = clip_count(tally);
        end
      end
      OP_COUNT: begin
        tally = 0;
        for (i = 0; i < entries_in_use(); i++)
          if (tbl_kind[i] == KIND_FREE) tally++;
        r.cnt = clip_count(tally);
      end
      OP_WRITE: begin
        if (!block_ok(blk) || (wkind == KIND_LINK && !block_ok(wlink))) begin
          r.status = ST_RANGE;
        end else begin
          cur = int'(blk) - 1;
          if (wkind == KIND_LINK) begin
            tbl_kind[cur] = KIND_LINK;
            tbl_link[cur] = wlink;
            r.blk  = wlink;
            r.kind = KIND_LINK;
          end else if (wkind == KIND_END) begin
            tbl_kind[cur] = KIND_END;
            tbl_link[cur] = '0;
            r.kind = KIND_END;
          end else begin
            // the unused kind code also frees the entry
            tbl_kind[cur] = KIND_FREE;
            tbl_link[cur] = '0;
            r.kind = KIND_FREE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // track register writes, predict on requests, compare on results
  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      for (int e = 0; e < ENTRIES; e++) begin
        tbl_kind[e] = KIND_FREE;
        tbl_link[e] = '0;
      end
      table_size = CFG_RESET;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) table_size = cfg_table_entries_i;
      if (in_valid_i && in_ready_i)
        pending_results.push_back(table_op_result(opcode_i, block_i, steps_i,
                                                  write_kind_i, write_link_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", status_i, '0);
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (block_out_i !== want.blk) report_mismatch("block_out", block_out_i, want.blk);
          if (kind_out_i !== want.kind) report_mismatch("kind_out", kind_out_i, want.kind);
          if (count_i !== want.cnt) report_mismatch("count", count_i, want.cnt);
        end
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

>>> sim/fat_chain_table_engine_unit_tb.sv
// fat_chain_table_engine_unit_tb: stimulus, idling and verdict for the chain table engine
// depends on fcte_pkg, fat_chain_table_engine_unit and fat_chain_table_checker
`timescale 1ns / 1ps

module fat_chain_table_engine_unit_tb;
  import fcte_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int          NUM_PHASES  = 12;

  // opcodes and entry kind without a meaning in the block
  localparam logic [OP_W-1:0]   OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_B = 3'd7;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_table_entries_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     opcode_i = '0;
  logic [BLK_W-1:0]    block_i = '0;
  logic [STEPS_W-1:0]  steps_i = '0;
  logic [KIND_W-1:0]   write_kind_i = '0;
  logic [BLK_W-1:0]    write_link_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [BLK_W-1:0]    block_out_o;
  logic [KIND_W-1:0]   kind_out_o;
  logic [BLK_W-1:0]    count_o;

  int                  pending_cnt;
  int                  fail_count;
  int unsigned         cycle_cnt = 0;
  int                  src_idle_pct = 0;
  int                  dst_stall_pct = 0;

  // per phase: table size, number of requests, block window
  int                  phase_size  [NUM_PHASES];
  int                  phase_items [NUM_PHASES];
  int                  phase_win   [NUM_PHASES];

  fat_chain_table_engine_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_table_entries_i (cfg_table_entries_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .block_i             (block_i),
    .steps_i             (steps_i),
    .write_kind_i        (write_kind_i),
    .write_link_i        (write_link_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .block_out_o         (block_out_o),
    .kind_out_o          (kind_out_o),
    .count_o             (count_o)
  );

  fat_chain_table_checker chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_table_entries_i (cfg_table_entries_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .opcode_i            (opcode_i),
    .block_i             (block_i),
    .steps_i             (steps_i),
    .write_kind_i        (write_kind_i),
    .write_link_i        (write_link_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_i            (status_o),
    .block_out_i         (block_out_o),
    .kind_out_i          (kind_out_o),
    .count_i             (count_o),
    .pending_o           (pending_cnt),
    .fail_count_o        (fail_count)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= dst_stall_pct);
  end

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                              input logic [STEPS_W-1:0] steps,
                              input logic [KIND_W-1:0] wkind,
                              input logic [BLK_W-1:0] wlink);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    block_i      <= blk;
    steps_i      <= steps;
    write_kind_i <= wkind;
    write_link_i <= wlink;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wait until every predicted result has come back
  task automatic wait_drained();
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] size);
    cfg_valid_i         <= 1'b1;
    cfg_table_entries_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // random request, mostly on blocks in a small window so chains build up
  task automatic random_request(input int win, input int size);
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [BLK_W-1:0]   blk;
    logic [STEPS_W-1:0] steps;
    logic [KIND_W-1:0]  wkind;
    logic [BLK_W-1:0]   wlink;
    pick = $urandom_range(99);
    if (pick < 14) op = OP_NEW;
    else if (pick < 40) op = OP_SEEK;
    else if (pick < 56) op = OP_READ;
    else if (pick < 68) op = OP_FREE;
    else if (pick < 70 || (pick < 74 && size <= 64)) op = OP_COUNT;
    else if (pick < 97) op = OP_WRITE;
    else op = pick[0] ? OP_SPARE_A : OP_SPARE_B;

    pick = $urandom_range(99);
    if (pick < 3) blk = '0;
    else if (pick < 6) blk = BLK_W'($urandom_range(2047, 1025));
    else if (pick < 8) blk = 11'd1024;
    else blk = BLK_W'($urandom_range(win, 1));

    pick = $urandom_range(99);
    if (pick < 5) steps = 10'd1023;
    else if (pick < 15) steps = STEPS_W'($urandom_range(1023, 0));
    else steps = STEPS_W'($urandom_range(6, 0));

    wkind = KIND_W'($urandom_range(3, 0));

    pick = $urandom_range(99);
    if (pick < 8) wlink = 11'd1024;
    else if (pick < 20) wlink = BLK_W'($urandom_range(2047, 0));
    else wlink = BLK_W'($urandom_range(win, 1));

    send_request(op, blk, steps, wkind, wlink);
  endtask

  // directed requests on the reset table size
  task automatic run_directed();
    send_request(OP_COUNT, 11'd1, 10'd0, KIND_LINK, 11'd1);       // empty table
    send_request(OP_NEW, 11'd0, 10'd0, KIND_LINK, 11'd0);         // block 1
    send_request(OP_NEW, 11'd2047, 10'd1023, KIND_BAD, 11'd2047); // block 2
    send_request(OP_SEEK, 11'd1, 10'd0, KIND_LINK, 11'd0);        // 1 -> 3
    send_request(OP_SEEK, 11'd1, 10'd1023, KIND_LINK, 11'd0);     // 3 -> 4
    send_request(OP_READ, 11'd1, 10'd0, KIND_LINK, 11'd0);
    send_request(OP_READ, 11'd1024, 10'd0, KIND_LINK, 11'd0);     // free entry
    send_request(OP_READ, 11'd0, 10'd0, KIND_LINK, 11'd0);        // out of range
    send_request(OP_SEEK, 11'd1025, 10'd0, KIND_LINK, 11'd0);     // out of range
    // self loop on the top entry, then a full-length walk around it
    send_request(OP_WRITE, 11'd1024, 10'd0, KIND_LINK, 11'd1024);
    send_request(OP_SEEK, 11'd1024, 10'd1023, KIND_LINK, 11'd0);
    send_request(OP_WRITE, 11'd5, 10'd0, KIND_LINK, 11'd0);       // bad link target
    send_request(OP_WRITE, 11'd6, 10'd0, KIND_LINK, 11'd1025);    // bad link target
    send_request(OP_WRITE, 11'd2, 10'd0, KIND_BAD, 11'd0);        // unused kind frees
    send_request(OP_WRITE, 11'd1000, 10'd0, KIND_END, 11'd2047);
    send_request(OP_WRITE, 11'd2047, 10'd0, KIND_END, 11'd1);     // out of range
    send_request(OP_FREE, 11'd1, 10'd0, KIND_LINK, 11'd0);        // frees 1, 3, 4
    send_request(OP_FREE, 11'd1, 10'd0, KIND_LINK, 11'd0);        // broken at head
    send_request(OP_SEEK, 11'd1, 10'd5, KIND_LINK, 11'd0);        // broken at head
    // link into a free entry, then free partway before the break
    send_request(OP_WRITE, 11'd10, 10'd0, KIND_LINK, 11'd11);
    send_request(OP_FREE, 11'd10, 10'd0, KIND_LINK, 11'd0);
    send_request(OP_FREE, 11'd0, 10'd0, KIND_LINK, 11'd0);
    send_request(OP_SPARE_A, 11'd7, 10'd9, KIND_BAD, 11'd2047);
    send_request(OP_SPARE_B, 11'd2047, 10'd1023, KIND_END, 11'd5);
    send_request(OP_COUNT, 11'd0, 10'd0, KIND_LINK, 11'd0);
  endtask

  // main sequence
  initial begin
    int p;
    int n;
    phase_size  = '{1024, 16, 1, 0, 64, 2047, 8, 40, 3, 1024, 24, 1024};
    phase_items = '{250, 200, 60, 40, 250, 150, 150, 250, 80, 150, 250, 150};
    phase_win   = '{48, 20, 6, 6, 70, 40, 12, 44, 6, 64, 28, 32};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      write_table_size(CFG_W'(phase_size[p]));
      // rotate through the idling modes
      case (p % 4)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 74; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 74; end
        default: begin src_idle_pct = 21; dst_stall_pct = 21; end
      endcase
      for (n = 0; n < phase_items[p]; n++) begin
        // hold off mid-phase until everything outstanding has returned
        if (n == phase_items[p] / 2 && p % 3 == 0) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        random_request(phase_win[p], phase_size[p]);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
